/* rtl/sm3_pkg.sv */
package sm3_pkg;

  localparam logic [31:0] TLow  = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;

  localparam logic [255:0] Iv = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  localparam logic [31:0] PadWord = 32'h80000000;

  // one queued word for the back end
  typedef struct packed {
    logic [31:0] word;
    logic        flush;   // last word of the message block: emit digest after
  } blk_word_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

/* rtl/sm3_hash_engine.sv */
// SM3 hash engine.
// Input channel: in_valid_i / in_stall_o with data_word_i (big-endian
// message bytes), valid_bytes_i (0..4, larger values taken as 4, used on the final word) and last_i.
// Output channel: out_valid_o / out_stall_i carrying digest_word_o,
// word_index_o and last_word_o; eight transfers per message.
// The front end takes one word per cycle unless in_stall_o is high,
// appends 0x80, zeros and the 64-bit bit length, and queues words for
// the compression core. The core loads 16 words (one per cycle while
// the queue has data) then runs 64 rounds, one per cycle, plus a fold
// step; it takes no new words until then, so the round loop sets the rate.
// After the final word the front end queues up to 18 padding and length
// words (the switch to the length words is a state step of its own);
// each block still to compress then runs through the core, and the
// digest leaves in eight output transfers.
// At reset the chaining value returns to the SM3 IV, counters clear.
// When the receiver stalls, the current digest word holds; the core and
// then the queue and front end back up, and in_stall_o rises.
module sm3_hash_engine #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sm3_pkg::*;

  blk_word_t f_word, c_word;
  logic      f_valid, f_stall, c_valid, c_stall;

  sm3_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_word_i, .valid_bytes_i, .last_i,
    .q_valid_o(f_valid), .q_stall_i(f_stall), .q_word_o(f_word)
  );

  sm3_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_word),
    .rd_valid_o(c_valid), .rd_stall_i(c_stall), .rd_data_o(c_word)
  );

  sm3_core u_core (
    .clk_i, .rst_ni,
    .q_valid_i(c_valid), .q_stall_o(c_stall), .q_word_i(c_word),
    .out_stall_i, .out_valid_o, .digest_word_o, .word_index_o, .last_word_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> !out_valid_o)
    else $error("digest ran past eighth word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=> out_valid_o)
    else $error("digest words not contiguous");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last flag mismatch");

endmodule

/* rtl/sm3_front.sv */
// Front end: counts bits, masks the final word and generates padding words.
module sm3_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [31:0]             data_word_i,
  input  logic [2:0]              valid_bytes_i,
  input  logic                    last_i,
  output logic                    q_valid_o,
  input  logic                    q_stall_i,
  output sm3_pkg::blk_word_t      q_word_o
);
  import sm3_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPad  = 4'b0010,
    StLenH = 4'b0100,
    StLenL = 4'b1000
  } fr_state_e;

  fr_state_e   state_q, state_d;
  logic [63:0] bits_q, bits_d;
  logic [3:0]  pos_q, pos_d;
  logic        pad80_q, pad80_d;   // 0x80 word still owed
  logic [2:0]  nb;
  logic [31:0] keep, masked;
  logic        push;

  always_comb begin
    nb = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    case (nb)
      3'd0:    keep = 32'h0;
      3'd1:    keep = 32'hff000000;
      3'd2:    keep = 32'hffff0000;
      3'd3:    keep = 32'hffffff00;
      default: keep = 32'hffffffff;
    endcase
    case (nb)
      3'd0:    masked = 32'h80000000;
      3'd1:    masked = (data_word_i & keep) | 32'h00800000;
      3'd2:    masked = (data_word_i & keep) | 32'h00008000;
      3'd3:    masked = (data_word_i & keep) | 32'h00000080;
      default: masked = data_word_i;
    endcase
  end

  assign push = q_valid_o && !q_stall_i;

  always_comb begin
    state_d   = state_q;
    bits_d    = bits_q;
    pos_d     = pos_q;
    pad80_d   = pad80_q;
    q_valid_o = 1'b0;
    q_word_o  = '{word: 32'h0, flush: 1'b0};
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        q_valid_o  = in_valid_i;
        q_word_o.word = last_i ? masked : data_word_i;
        in_stall_o = q_stall_i;
        if (in_valid_i && !q_stall_i) begin
          pos_d  = pos_q + 4'd1;
          bits_d = bits_q + (last_i ? {58'd0, nb, 3'd0} : 64'd32);
          if (last_i) begin
            pad80_d = (nb == 3'd4);
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (!pad80_q && pos_q == 4'd14) begin
          state_d = StLenH;
        end else begin
          q_valid_o = 1'b1;
          if (pad80_q) q_word_o.word = PadWord;
          if (!q_stall_i) begin
            pad80_d = 1'b0;
            pos_d = pos_q + 4'd1;
          end
        end
      end
      StLenH: begin
        q_valid_o = 1'b1;
        q_word_o.word = bits_q[63:32];
        if (!q_stall_i) state_d = StLenL;
      end
      StLenL: begin
        q_valid_o = 1'b1;
        q_word_o.word  = bits_q[31:0];
        q_word_o.flush = 1'b1;
        if (!q_stall_i) begin
          state_d = StIdle;
          bits_d  = 64'd0;
          pos_d   = 4'd0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bits_q  <= 64'd0;
      pos_q   <= 4'd0;
      pad80_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bits_q  <= bits_d;
      pos_q   <= pos_d;
      pad80_q <= pad80_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLenH) |-> (pos_q == 4'd14))
    else $error("length word not at position 14");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_word_o.flush) |=> (state_q == StIdle && bits_q == 64'd0))
    else $error("front did not restart after flush");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o)
    else $error("input taken during padding");

endmodule

/* rtl/sm3_fifo.sv */
// Small queue between front and back end.
module sm3_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_stall_o,
  input  sm3_pkg::blk_word_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_stall_i,
  output sm3_pkg::blk_word_t rd_data_o
);
  import sm3_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  blk_word_t           mem_q [Depth];
  logic [AW-1:0]       wp_q, rp_q;
  logic [AW:0]         cnt_q;
  logic                wr, rd;

  assign wr_stall_o = (cnt_q == (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
      if (rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> (cnt_q == $past(cnt_q) + (AW+1)'(1)))
    else $error("queue count slip");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && !wr) |=> (cnt_q == $past(cnt_q) - (AW+1)'(1)))
    else $error("queue count slip");

endmodule

/* rtl/sm3_core.sv */
// Back end: collects 16 words, compresses with one round per cycle,
// message expansion on the fly in a 16-word window, emits the digest.
module sm3_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_stall_o,
  input  sm3_pkg::blk_word_t q_word_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);
  import sm3_pkg::*;

  typedef enum logic [3:0] {
    StLoad  = 4'b0001,
    StRound = 4'b0010,
    StFold  = 4'b0100,
    StOut   = 4'b1000
  } core_state_e;

  core_state_e  state_q;
  logic [31:0]  w_q [16];
  logic [31:0]  v_q [8];
  logic [31:0]  r_q [8];
  logic [3:0]   pos_q;
  logic [5:0]   rnd_q;
  logic [2:0]   oidx_q;
  logic         flush_q;
  logic         take;
  logic [31:0]  a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew;

  assign q_stall_o = (state_q != StLoad);
  assign take = q_valid_i && (state_q == StLoad);

  always_comb begin
    tj   = rotl((rnd_q < 6'd16) ? TLow : THigh, rnd_q[4:0]);
    a12  = rotl(r_q[0], 5'd12);
    ss1  = rotl(a12 + r_q[4] + tj, 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd_q < 6'd16) begin
      ff = r_q[0] ^ r_q[1] ^ r_q[2];
      gg = r_q[4] ^ r_q[5] ^ r_q[6];
    end else begin
      ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
      gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
    end
    tt1  = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2  = gg + r_q[7] + ss1 + w_q[0];
    // W[j+16] from the window W[j..j+15]
    wnew = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  end

  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = v_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (take) w_q[pos_q] <= q_word_i.word;
    if (state_q == StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      pos_q   <= 4'd0;
      rnd_q   <= 6'd0;
      oidx_q  <= 3'd0;
      flush_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= Iv[255-32*i -: 32];
        r_q[i] <= 32'h0;
      end
    end else begin
      case (state_q)
        StLoad: if (take) begin
          pos_q <= pos_q + 4'd1;
          if (pos_q == 4'd15) begin
            flush_q <= q_word_i.flush;
            rnd_q   <= 6'd0;
            for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
            state_q <= StRound;
          end
        end
        StRound: begin
          r_q[3] <= r_q[2];
          r_q[2] <= rotl(r_q[1], 5'd9);
          r_q[1] <= r_q[0];
          r_q[0] <= tt1;
          r_q[7] <= r_q[6];
          r_q[6] <= rotl(r_q[5], 5'd19);
          r_q[5] <= r_q[4];
          r_q[4] <= perm0(tt2);
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= StFold;
        end
        StFold: begin
          for (int i = 0; i < 8; i++) v_q[i] <= v_q[i] ^ r_q[i];
          oidx_q  <= 3'd0;
          state_q <= flush_q ? StOut : StLoad;
        end
        StOut: if (!out_stall_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) v_q[i] <= Iv[255-32*i -: 32];
            state_q <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == 6'd63) |=> (state_q == StFold))
    else $error("round count slip");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (pos_q == 4'd0))
    else $error("digest with partial block");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(oidx_q)))
    else $error("stalled digest word moved");

endmodule

/* verif/sm3_digest_checker.sv */
`timescale 1ns / 100ps

module sm3_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned digests_o,
  output logic        activity_o
);
  import sm3_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain_q [8];
  logic [31:0]  blk_q [16];
  logic [63:0]  msg_bits;
  int unsigned  blk_pos;
  digest_beat_t digest_fifo [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    int k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [31:0] p0f(input logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] p1f(input logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  task automatic compress();
    logic [31:0] w [68];
    logic [31:0] v [8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int j = 0; j < 16; j++) w[j] = blk_q[j];
    for (int j = 16; j < 68; j++)
      w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    for (int j = 0; j < 8; j++) v[j] = chain_q[j];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? TLow : THigh;
      a12 = rol(v[0], 12);
      ss1 = rol(a12 + v[4] + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4]; v[4] = p0f(tt2);
    end
    for (int j = 0; j < 8; j++) chain_q[j] ^= v[j];
  endtask

  task automatic append_word(input logic [31:0] w);
    blk_q[blk_pos] = w;
    blk_pos = (blk_pos + 1) % 16;
    if (blk_pos == 0) compress();
  endtask

  task automatic reset_chain();
    for (int j = 0; j < 8; j++) chain_q[j] = Iv[255 - 32*j -: 32];
    msg_bits = '0;
    blk_pos = 0;
  endtask

  task automatic absorb(input logic [31:0] d, input logic [2:0] nb_in, input logic lst);
    int unsigned nb;
    logic [31:0] keep;
    digest_beat_t b;
    if (!lst) begin
      msg_bits += 64'd32;
      append_word(d);
      return;
    end
    nb = (nb_in > 4) ? 4 : nb_in;
    msg_bits += 64'(nb * 8);
    if (nb == 4) begin
      append_word(d);
      append_word(PadWord);
    end else begin
      keep = (nb == 0) ? 32'h0 : (32'hffffffff << (8 * (4 - nb)));
      append_word((d & keep) | (32'h80 << (8 * (3 - nb))));
    end
    while (blk_pos != 14) append_word(32'h0);
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    for (int k = 0; k < 8; k++) begin
      b.word = chain_q[k];
      b.index = 3'(k);
      b.last = (k == 7);
      digest_fifo.push_back(b);
    end
    reset_chain();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    digests_o = 0;
    reset_chain();
  end

  assign pending_o = digest_fifo.size();
  assign activity_o = (in_valid_i && !in_stall_i) || (out_valid_i && !out_stall_i);

  always @(posedge clk_i) begin
    digest_beat_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) absorb(data_word_i, valid_bytes_i, last_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_fifo.size() == 0) begin
          report("unexpected digest word", digest_word_i, 32'h0);
        end else begin
          e = digest_fifo.pop_front();
          if (digest_word_i !== e.word) report("digest_word", digest_word_i, e.word);
          if (word_index_i !== e.index) report("word_index", 32'(word_index_i), 32'(e.index));
          if (last_word_i !== e.last) report("last_word", 32'(last_word_i), 32'(e.last));
          if (e.last) digests_o++;
        end
      end
    end
  end

endmodule

/* verif/tb_sm3_hash_engine.sv */
`timescale 1ns / 100ps

// Testbench top: drives messages into the SM3 engine and gives the
// verdict. Prediction and comparison live in sm3_digest_checker.
module tb_sm3_hash_engine;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] data_word_i;
  logic [2:0]  valid_bytes_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  int unsigned fail_cnt, pending, digests;
  logic        activity;
  int unsigned words_sent;
  int unsigned idle_cycles;
  bit          calm;      // no idling on either side while set
  bit          timed_out;

  // watchdog: cycles with no transfer on either channel. Worst case is
  // padding plus two blocks plus heavy output stall, far below this.
  localparam int unsigned StallLimit = 5000;

  sm3_hash_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_word_i,
    .valid_bytes_i, .last_i, .out_valid_o, .out_stall_i,
    .digest_word_o, .word_index_o, .last_word_o
  );

  sm3_digest_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .data_word_i, .valid_bytes_i, .last_i, .out_valid_i(out_valid_o),
    .out_stall_i, .digest_word_i(digest_word_o), .word_index_i(word_index_o),
    .last_word_i(last_word_o), .fail_cnt_o(fail_cnt), .pending_o(pending),
    .digests_o(digests), .activity_o(activity)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: stalls at random about 17 percent of the time, except in calm stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 17);
    end
  end

  // Watchdog on transfer-free cycles.
  always @(posedge clk_i) begin
    if (!rst_ni || activity) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // One word transfer, with an optional random gap before it.
  task automatic send_word(input logic [31:0] d, input logic [2:0] nb, input logic lst);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_word_i   <= d;
    valid_bytes_i <= nb;
    last_i        <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Message of nw words; the final one carries nb valid bytes.
  task automatic send_msg(input int nw, input logic [2:0] nb);
    for (int i = 0; i < nw; i++)
      send_word($urandom(), (i == nw - 1) ? nb : 3'($urandom_range(7)), i == nw - 1);
    in_valid_i <= 1'b0;
  endtask

  initial begin
    in_valid_i    = 1'b0;
    data_word_i   = '0;
    valid_bytes_i = 3'd4;
    last_i        = 1'b0;
    out_stall_i   = 1'b0;
    rst_ni        = 1'b0;
    calm          = 1'b0;
    words_sent    = 0;
    idle_cycles   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, the classic "abc", field extremes,
    // every tail length, out-of-range byte counts, padding that spills
    // into an extra block (14, 15 words), no zero words (13 words), exact 16-word block.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h00000000, 3'd2, 1'b1);
    send_word(32'ha5a5a5a5, 3'd7, 1'b1);
    send_word(32'h5a5a5a5a, 3'd5, 1'b1);
    send_msg(13, 3'd4);
    send_msg(14, 3'd4);
    send_msg(15, 3'd2);
    send_msg(16, 3'd4);
    in_valid_i <= 1'b0;

    // Random: mostly short messages, a few long ones, through a
    // no-idle stretch in the middle.
    while (words_sent < 120) begin
      calm = (words_sent >= 60 && words_sent < 95);
      if ($urandom_range(9) == 0) send_msg($urandom_range(17, 40), 3'($urandom_range(7)));
      else send_msg($urandom_range(1, 16), 3'($urandom_range(7)));
    end
    calm = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("sent %0d message words, checked %0d digests", words_sent, digests);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
